### hw/rtl/breakpoint_gain_interpolator_assert.svh
// Assertion macros used by the top-level RTL.
`ifndef BREAKPOINT_GAIN_INTERPOLATOR_ASSERT_SVH
`define BREAKPOINT_GAIN_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BGI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bgi assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BGI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bgi assertion failed");

`endif

### hw/rtl/bgi_pkg.sv
`default_nettype none
package bgi_pkg;

	localparam int DEPTH = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DVD_W = 32;
	localparam int DSR_W = 16;
	localparam int DCNT_W = $clog2(DVD_W);

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_INTERP = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_COUNT  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND,
		S_FEND,
		S_SHUP,
		S_SHUP_WR,
		S_SHDN,
		S_SHDN_WR,
		S_DIV,
		S_DIVW
	} state_t;

	typedef enum logic [2:0] {
		RD_IDX,
		RD_ZERO,
		RD_P1,
		RD_M1,
		RD_PC
	} rd_sel_t;

	typedef struct packed {
		logic    load;
		rd_sel_t rd_sel;
		logic    advance;
		logic    idx_inc;
		logic    idx_dec;
		logic    idx_to_used;
		logic    idx_to_start;
		logic    save_start;
		logic    set_count;
		logic    wr_new;
		logic    wr_copy;
		logic    used_inc;
		logic    used_sub;
		logic    mul;
		logic    div_start;
		logic    set_gain_rd;
		logic    set_gain_prev;
		logic    set_gain_div;
		logic    set_full;
		logic    finish;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  in_range;
		logic  lt_key;
		logic  lt_end;
		logic  eq_key;
		logic  idx_zero;
		logic  used_zero;
		logic  used_full;
		logic  range_empty;
		logic  at_start;
		logic  shdn_more;
		logic  div_done;
	} stat_t;

endpackage
`default_nettype wire

### hw/rtl/breakpoint_gain_interpolator.sv
// Breakpoint gain table with linear interpolation.
// Issue an item by raising start while busy is low; kind, key_time, range_end
// and gain_in are sampled at that edge. Kinds: insert, interpolate, remove
// range, count range. Exactly one result per item: done is high for one
// cycle with gain_out, point_count and table_full; the receiver cannot stall.
// The table is scanned one entry per cycle from index 0 (memory read port).
// Insert then moves each entry after the key up one place; remove moves
// the entries after the range down. Interpolation between points adds a
// bit-serial divider; busy stays high until done is issued.
// A new item may be started in the cycle done is high.
// Reset clears the point count and the controller; table contents are left
// as they are and only written entries are ever read.
`default_nettype none
module breakpoint_gain_interpolator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         kind,
	input  wire logic [15:0]        key_time,
	input  wire logic [15:0]        range_end,
	input  wire logic signed [15:0] gain_in,
	output logic                    done,
	output logic signed [15:0]      gain_out,
	output logic [5:0]              point_count,
	output logic                    table_full
);

	bgi_pkg::cmd_t  cmd;
	bgi_pkg::stat_t stat;

	bgi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	bgi_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.kind        (kind),
		.key_time    (key_time),
		.range_end   (range_end),
		.gain_in     (gain_in),
		.stat        (stat),
		.done        (done),
		.gain_out    (gain_out),
		.point_count (point_count),
		.table_full  (table_full)
	);

`include "breakpoint_gain_interpolator_assert.svh"

	`BGI_ASSERT_IMP(a_done_idle, done, !busy)
	`BGI_ASSERT_NXT(a_start_busy, start && !busy, busy)
	`BGI_ASSERT_IMP(a_full_clean, done && table_full, gain_out == 16'sd0 && point_count == 6'd0)

endmodule
`default_nettype wire

### hw/rtl/bgi_div.sv
`default_nettype none
module bgi_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [bgi_pkg::DVD_W-1:0]  dividend,
	input  wire logic [bgi_pkg::DSR_W-1:0]  divisor,
	output logic      [bgi_pkg::DVD_W-1:0]  quotient,
	output logic                            done
);

	logic                         run_q;
	logic                         done_q;
	logic [bgi_pkg::DCNT_W-1:0]   cnt_q;
	logic [bgi_pkg::DVD_W-1:0]    dvd_q;
	logic [bgi_pkg::DSR_W-1:0]    dsr_q;
	logic [bgi_pkg::DSR_W-1:0]    rem_q;
	logic [bgi_pkg::DSR_W:0]      trial;
	logic                         qbit;

	assign trial = {rem_q, dvd_q[bgi_pkg::DVD_W-1]};
	assign qbit  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == bgi_pkg::DCNT_W'(bgi_pkg::DVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, shifted into the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= qbit ? bgi_pkg::DSR_W'(trial - {1'b0, dsr_q})
			              : trial[bgi_pkg::DSR_W-1:0];
			dvd_q <= {dvd_q[bgi_pkg::DVD_W-2:0], qbit};
		end
	end

	assign quotient = dvd_q;
	assign done     = done_q;

endmodule
`default_nettype wire

### hw/rtl/bgi_dpath.sv
`default_nettype none
module bgi_dpath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bgi_pkg::cmd_t       cmd,
	input  wire logic [1:0]          kind,
	input  wire logic [15:0]         key_time,
	input  wire logic [15:0]         range_end,
	input  wire logic signed [15:0]  gain_in,
	output bgi_pkg::stat_t           stat,
	output logic                     done,
	output logic signed [15:0]       gain_out,
	output logic [5:0]               point_count,
	output logic                     table_full
);

	logic [15:0] mem_t [bgi_pkg::DEPTH];
	logic [15:0] mem_g [bgi_pkg::DEPTH];
	logic [15:0] t_rd, g_rd;
	logic [bgi_pkg::IDX_W-1:0] raddr, waddr;
	logic [15:0] wt, wg;
	logic        we;

	bgi_pkg::kind_t kind_q;
	logic [15:0] key_q, rend_q, gin_q;
	logic [15:0] prev_t_q, prev_g_q;
	logic [bgi_pkg::CNT_W-1:0] idx_q, start_q, count_q, used_q, span;
	logic signed [33:0] prod_q;
	logic [15:0] dt_q;
	logic signed [16:0] dg;
	logic [15:0] dk;
	logic [31:0] mag;
	logic [31:0] quot;
	logic        div_done;
	logic [15:0] qadj;
	logic [15:0] res_gain_q;
	logic [bgi_pkg::CNT_W-1:0] res_cnt_q;
	logic        res_full_q, done_q;
	logic [bgi_pkg::CNT_W:0] reach;

	always_comb begin
		unique case (cmd.rd_sel)
			bgi_pkg::RD_IDX:  raddr = idx_q[bgi_pkg::IDX_W-1:0];
			bgi_pkg::RD_ZERO: raddr = '0;
			bgi_pkg::RD_P1:   raddr = bgi_pkg::IDX_W'(idx_q + 1'b1);
			bgi_pkg::RD_M1:   raddr = bgi_pkg::IDX_W'(idx_q - 1'b1);
			bgi_pkg::RD_PC:   raddr = bgi_pkg::IDX_W'(idx_q + count_q);
			default:          raddr = idx_q[bgi_pkg::IDX_W-1:0];
		endcase
	end

	assign we    = cmd.wr_new | cmd.wr_copy;
	assign waddr = idx_q[bgi_pkg::IDX_W-1:0];
	assign wt    = cmd.wr_new ? key_q : t_rd;
	assign wg    = cmd.wr_new ? gin_q : g_rd;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_t[waddr] <= wt;
			mem_g[waddr] <= wg;
		end
		t_rd <= mem_t[raddr];
		g_rd <= mem_g[raddr];
	end

	assign span  = idx_q - start_q;
	assign dg    = $signed({g_rd[15], g_rd}) - $signed({prev_g_q[15], prev_g_q});
	assign dk    = key_q - prev_t_q;
	assign mag   = prod_q[33] ? 32'(-prod_q) : prod_q[31:0];
	assign qadj  = prod_q[33] ? 16'(-quot[15:0]) : quot[15:0];
	assign reach = {1'b0, idx_q} + {1'b0, count_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= bgi_pkg::kind_t'(kind);
			key_q  <= key_time;
			rend_q <= range_end;
			gin_q  <= gain_in;
		end
		if (cmd.advance) begin
			prev_t_q <= t_rd;
			prev_g_q <= g_rd;
		end
		if (cmd.save_start) start_q <= idx_q;
		if (cmd.set_count)  count_q <= span;
		if (cmd.mul) begin
			prod_q <= dg * $signed({1'b0, dk});
			dt_q   <= t_rd - prev_t_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			used_q     <= '0;
			res_gain_q <= '0;
			res_cnt_q  <= '0;
			res_full_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.load)                         idx_q <= '0;
			else if (cmd.advance || cmd.idx_inc)  idx_q <= idx_q + 1'b1;
			else if (cmd.idx_dec)                 idx_q <= idx_q - 1'b1;
			else if (cmd.idx_to_used)             idx_q <= used_q;
			else if (cmd.idx_to_start)            idx_q <= start_q;
			if (cmd.used_inc)      used_q <= used_q + 1'b1;
			else if (cmd.used_sub) used_q <= used_q - count_q;
			if (cmd.load) begin
				res_gain_q <= '0;
				res_cnt_q  <= '0;
				res_full_q <= 1'b0;
			end
			if (cmd.set_count)     res_cnt_q  <= span;
			if (cmd.set_full)      res_full_q <= 1'b1;
			if (cmd.set_gain_rd)   res_gain_q <= g_rd;
			if (cmd.set_gain_prev) res_gain_q <= prev_g_q;
			if (cmd.set_gain_div)  res_gain_q <= prev_g_q + qadj;
		end
	end

	bgi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (mag),
		.divisor  (dt_q),
		.quotient (quot),
		.done     (div_done)
	);

	always_comb begin
		stat.kind        = kind_q;
		stat.in_range    = idx_q < used_q;
		stat.lt_key      = stat.in_range && (t_rd < key_q);
		stat.lt_end      = stat.in_range && (t_rd < rend_q);
		stat.eq_key      = stat.in_range && (t_rd == key_q);
		stat.idx_zero    = idx_q == '0;
		stat.used_zero   = used_q == '0;
		stat.used_full   = used_q == bgi_pkg::CNT_W'(bgi_pkg::DEPTH);
		stat.range_empty = rend_q <= key_q;
		stat.at_start    = idx_q == start_q;
		stat.shdn_more   = reach < {1'b0, used_q};
		stat.div_done    = div_done;
	end

	assign done        = done_q;
	assign gain_out    = $signed(res_gain_q);
	assign point_count = 6'(res_cnt_q);
	assign table_full  = res_full_q;

endmodule
`default_nettype wire

### hw/rtl/bgi_ctrl.sv
`default_nettype none
module bgi_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire bgi_pkg::stat_t  stat,
	output bgi_pkg::cmd_t        cmd,
	output logic                 busy
);

	bgi_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= bgi_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bgi_pkg::S_IDLE: if (start) state_d = bgi_pkg::S_FIND;
			bgi_pkg::S_FIND: begin
				if (!stat.lt_key) begin
					unique case (stat.kind)
						bgi_pkg::KIND_INSERT:
							if (stat.eq_key || stat.used_full) state_d = bgi_pkg::S_IDLE;
							else                               state_d = bgi_pkg::S_SHUP;
						bgi_pkg::KIND_INTERP:
							if (stat.used_zero || !stat.in_range || stat.idx_zero || stat.eq_key)
								state_d = bgi_pkg::S_IDLE;
							else
								state_d = bgi_pkg::S_DIV;
						default:
							if (stat.range_empty) state_d = bgi_pkg::S_IDLE;
							else                  state_d = bgi_pkg::S_FEND;
					endcase
				end
			end
			bgi_pkg::S_FEND: begin
				if (!stat.lt_end) begin
					if (stat.kind == bgi_pkg::KIND_COUNT || stat.at_start)
						state_d = bgi_pkg::S_IDLE;
					else
						state_d = bgi_pkg::S_SHDN;
				end
			end
			bgi_pkg::S_SHUP:
				state_d = stat.at_start ? bgi_pkg::S_IDLE : bgi_pkg::S_SHUP_WR;
			bgi_pkg::S_SHUP_WR: state_d = bgi_pkg::S_SHUP;
			bgi_pkg::S_SHDN:
				state_d = stat.shdn_more ? bgi_pkg::S_SHDN_WR : bgi_pkg::S_IDLE;
			bgi_pkg::S_SHDN_WR: state_d = bgi_pkg::S_SHDN;
			bgi_pkg::S_DIV:     state_d = bgi_pkg::S_DIVW;
			bgi_pkg::S_DIVW:    if (stat.div_done) state_d = bgi_pkg::S_IDLE;
			default:            state_d = bgi_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_sel = bgi_pkg::RD_IDX;
		unique case (state_q)
			bgi_pkg::S_IDLE: begin
				cmd.rd_sel = bgi_pkg::RD_ZERO;
				cmd.load   = start;
			end
			bgi_pkg::S_FIND: begin
				if (stat.lt_key) begin
					cmd.advance = 1'b1;
					cmd.rd_sel  = bgi_pkg::RD_P1;
				end else begin
					unique case (stat.kind)
						bgi_pkg::KIND_INSERT: begin
							if (stat.eq_key) begin
								cmd.wr_new = 1'b1;
								cmd.finish = 1'b1;
							end else if (stat.used_full) begin
								cmd.set_full = 1'b1;
								cmd.finish   = 1'b1;
							end else begin
								cmd.save_start  = 1'b1;
								cmd.idx_to_used = 1'b1;
							end
						end
						bgi_pkg::KIND_INTERP: begin
							if (stat.used_zero) begin
								cmd.finish = 1'b1;
							end else if (!stat.in_range) begin
								cmd.set_gain_prev = 1'b1;
								cmd.finish        = 1'b1;
							end else if (stat.idx_zero || stat.eq_key) begin
								cmd.set_gain_rd = 1'b1;
								cmd.finish      = 1'b1;
							end else begin
								cmd.mul = 1'b1;
							end
						end
						default: begin
							if (stat.range_empty) cmd.finish     = 1'b1;
							else                  cmd.save_start = 1'b1;
						end
					endcase
				end
			end
			bgi_pkg::S_FEND: begin
				if (stat.lt_end) begin
					cmd.advance = 1'b1;
					cmd.rd_sel  = bgi_pkg::RD_P1;
				end else begin
					cmd.set_count = 1'b1;
					if (stat.kind == bgi_pkg::KIND_COUNT || stat.at_start)
						cmd.finish = 1'b1;
					else
						cmd.idx_to_start = 1'b1;
				end
			end
			bgi_pkg::S_SHUP: begin
				if (stat.at_start) begin
					cmd.wr_new   = 1'b1;
					cmd.used_inc = 1'b1;
					cmd.finish   = 1'b1;
				end else begin
					cmd.rd_sel = bgi_pkg::RD_M1;
				end
			end
			bgi_pkg::S_SHUP_WR: begin
				cmd.wr_copy = 1'b1;
				cmd.idx_dec = 1'b1;
			end
			bgi_pkg::S_SHDN: begin
				if (stat.shdn_more) begin
					cmd.rd_sel = bgi_pkg::RD_PC;
				end else begin
					cmd.used_sub = 1'b1;
					cmd.finish   = 1'b1;
				end
			end
			bgi_pkg::S_SHDN_WR: begin
				cmd.wr_copy = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			bgi_pkg::S_DIV: cmd.div_start = 1'b1;
			bgi_pkg::S_DIVW: begin
				if (stat.div_done) begin
					cmd.set_gain_div = 1'b1;
					cmd.finish       = 1'b1;
				end
			end
			default: cmd.rd_sel = bgi_pkg::RD_IDX;
		endcase
	end

	assign busy = state_q != bgi_pkg::S_IDLE;

endmodule
`default_nettype wire
